// File: rtl/tmr_pkg.sv
`timescale 1ns / 1ps
// Package for the timestamp reclocker: sizes, register indexes, reset values
// and the types shared by the state memory, the update logic and the top level.
package tmr_pkg;

   localparam int NUM_STREAMS = 16;
   localparam int SID_W       = 4;
   localparam int IDX_W       = (NUM_STREAMS > 1) ? $clog2(NUM_STREAMS) : 1;
   localparam int TS_W        = 64;
   localparam int DUR_W       = 32;
   localparam int THR_W       = 63;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_ENABLE   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JUMP_THR = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CORR_THR = 2'd2;

   localparam logic             ENABLE_RESET   = 1'b1;
   localparam logic [THR_W-1:0] JUMP_THR_RESET = 63'd10000000;
   localparam logic [THR_W-1:0] CORR_THR_RESET = 63'd1000000;

   typedef logic [IDX_W-1:0] stream_idx_type;

   typedef struct packed {
      logic [TS_W-1:0] ep;
      logic [TS_W-1:0] ed;
      logic [TS_W-1:0] off;
   } entry_type;

   typedef struct packed {
      logic           en;
      stream_idx_type addr;
      entry_type      data;
   } mem_wr_type;

   typedef struct packed {
      logic [TS_W-1:0] pts_out;
      logic [TS_W-1:0] dts_out;
      logic            jump_seen;
      logic            offset_updated;
   } result_type;

endpackage

// File: rtl/tmr_state_mem.sv
`timescale 1ns / 1ps
// Per-stream state memory: expected pts/dts and offset in a synchronous RAM,
// started flags in flops, last-write forwarding. Uses tmr_pkg.
module tmr_state_mem (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 rd_en,
   input  tmr_pkg::stream_idx_type rd_addr,
   input  tmr_pkg::mem_wr_type  wr,
   output logic                 rd_started,
   output tmr_pkg::entry_type   rd_entry
);
   import tmr_pkg::*;

   entry_type           ram_ff [NUM_STREAMS];
   entry_type           rd_data_ff;
   stream_idx_type      rd_addr_ff;
   logic [NUM_STREAMS-1:0] started_ff;
   logic                last_vld_ff;
   stream_idx_type      last_addr_ff;
   entry_type           last_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         ram_ff[wr.addr] <= wr.data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
         rd_addr_ff <= rd_addr;
      end
      if (wr.en) begin
         last_addr_ff <= wr.addr;
         last_data_ff <= wr.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff  <= '0;
         last_vld_ff <= 1'b0;
      end else if (wr.en) begin
         started_ff[wr.addr] <= 1'b1;
         last_vld_ff         <= 1'b1;
      end
   end

   // read-old RAM: a write on the read edge is picked up from the last-write copy
   assign rd_entry   = (last_vld_ff && last_addr_ff == rd_addr_ff) ? last_data_ff : rd_data_ff;
   assign rd_started = started_ff[rd_addr_ff];

endmodule

// File: rtl/tmr_calc.sv
`timescale 1ns / 1ps
// Update logic for one item: jump check, offset apply, offset correction
// and next expected timestamps. Combinational; uses tmr_pkg.
module tmr_calc (
   input  logic                      enable,
   input  logic [tmr_pkg::THR_W-1:0] jump_thr,
   input  logic [tmr_pkg::THR_W-1:0] corr_thr,
   input  logic                      in_range,
   input  logic                      started,
   input  tmr_pkg::stream_idx_type   idx,
   input  tmr_pkg::entry_type        entry,
   input  logic [tmr_pkg::TS_W-1:0]  pts_in,
   input  logic [tmr_pkg::TS_W-1:0]  dts_in,
   input  logic [tmr_pkg::DUR_W-1:0] dur,
   output tmr_pkg::result_type       result,
   output tmr_pkg::mem_wr_type       wr
);
   import tmr_pkg::*;

   logic             pv, dv, active, pterm, dterm;
   logic [TS_W-1:0]  d_diff, p_diff, d_abs, p_abs;
   logic [THR_W-1:0] dmag, pmag;
   logic [TS_W-1:0]  pts_o, dts_o, new_off, dur_ext;
   logic             upd;

   always_comb begin
      pv      = ~pts_in[TS_W-1];
      dv      = ~dts_in[TS_W-1];
      active  = enable && (pv || dv) && in_range;
      dterm   = dv && ~entry.ed[TS_W-1];
      pterm   = pv && ~entry.ep[TS_W-1];
      d_diff  = entry.ed - dts_in;
      p_diff  = entry.ep - pts_in;
      d_abs   = d_diff[TS_W-1] ? (~d_diff + 1'b1) : d_diff;
      p_abs   = p_diff[TS_W-1] ? (~p_diff + 1'b1) : p_diff;
      dmag    = dterm ? d_abs[THR_W-1:0] : '0;
      pmag    = pterm ? p_abs[THR_W-1:0] : '0;
      dur_ext = {{(TS_W-DUR_W){1'b0}}, dur};
      pts_o   = pv ? pts_in + entry.off : pts_in;
      dts_o   = dv ? dts_in + entry.off : dts_in;
      upd     = (dmag > corr_thr) || (pmag > corr_thr);

      priority if (upd && dmag > pmag && dmag != '0) begin
         new_off = entry.off + d_diff;
      end else if (upd && pmag != '0) begin
         new_off = entry.off + p_diff;
      end else begin
         new_off = entry.off;
      end

      result.pts_out        = pts_in;
      result.dts_out        = dts_in;
      result.jump_seen      = 1'b0;
      result.offset_updated = 1'b0;
      wr.en                 = active;
      wr.addr               = idx;
      wr.data.ep            = pts_in;
      wr.data.ed            = dts_in;
      wr.data.off           = '0;

      if (active && started) begin
         result.pts_out        = pts_o;
         result.dts_out        = dts_o;
         result.jump_seen      = (dmag > jump_thr) || (pmag > jump_thr);
         result.offset_updated = upd;
         wr.data.ep            = pts_o + dur_ext;
         wr.data.ed            = dts_o + dur_ext;
         wr.data.off           = new_off;
      end
   end

endmodule

// File: rtl/timestamp_monotonic_reclock_top.sv
`timescale 1ns / 1ps
// Top level of the per-stream timestamp reclocker: control registers,
// input stage, output register. Uses tmr_pkg, tmr_state_mem, tmr_calc.
//
// Usage:
//   req_* carries packets: req_tdata = {pkt_duration, dts_in, pts_in},
//   req_tuser = stream_id. rsp_* returns one item per packet:
//   rsp_tdata = {dts_out, pts_out}, rsp_tuser = {offset_updated, jump_seen}.
//   csr_* writes a control register (0 enable, 1 jump threshold,
//   2 correction threshold) with one write per accepted csr item.
// Timing: the stream's state RAM is read at the accepting edge; the edge on
//   which the input stage advances updates it, loads the output register and
//   raises rsp_tvalid.
// Throughput: one packet per cycle while rsp_tready is high, even back-to-back
//   in one stream; the state RAM write of a packet is forwarded to the next.
// Reset: synchronous, clears all started flags and restores register
//   defaults; the RAM itself is never cleared, an entry is seeded by its
//   stream's first packet. No clearing pass, items are taken right away.
// Stall: while rsp_tready is low the output register holds and one more
//   packet waits in the input stage; then req_tready drops.
module timestamp_monotonic_reclock_top (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [159:0]                   req_tdata,  // pts_in, dts_in, pkt_duration
   input  logic [tmr_pkg::SID_W-1:0]      req_tuser,  // stream_id
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [127:0]                   rsp_tdata,  // pts_out, dts_out
   output logic [1:0]                     rsp_tuser,  // jump_seen, offset_updated
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [tmr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmr_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmr_pkg::*;

   logic             enable_ff;
   logic [THR_W-1:0] jump_thr_ff, corr_thr_ff;

   logic             s1_valid_ff;
   logic [SID_W-1:0] s1_sid_ff;
   logic [TS_W-1:0]  s1_pts_ff, s1_dts_ff;
   logic [DUR_W-1:0] s1_dur_ff;

   logic             rsp_valid_ff;
   result_type       rsp_data_ff;

   logic             req_acc, s1_adv, in_range, started;
   entry_type        entry;
   result_type       calc_res;
   mem_wr_type       calc_wr, mem_wr;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         enable_ff   <= ENABLE_RESET;
         jump_thr_ff <= JUMP_THR_RESET;
         corr_thr_ff <= CORR_THR_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ENABLE:   enable_ff   <= csr_wdata[0];
            CSR_JUMP_THR: jump_thr_ff <= csr_wdata[THR_W-1:0];
            CSR_CORR_THR: corr_thr_ff <= csr_wdata[THR_W-1:0];
            default:      ;
         endcase
      end
   end

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_tready) begin
         s1_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_sid_ff <= req_tuser;
         s1_pts_ff <= req_tdata[63:0];
         s1_dts_ff <= req_tdata[127:64];
         s1_dur_ff <= req_tdata[159:128];
      end
   end

   assign in_range = int'(s1_sid_ff) < NUM_STREAMS;

   tmr_state_mem u_mem (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (req_acc),
      .rd_addr    (IDX_W'(req_tuser)),
      .wr         (mem_wr),
      .rd_started (started),
      .rd_entry   (entry)
   );

   tmr_calc u_calc (
      .enable   (enable_ff),
      .jump_thr (jump_thr_ff),
      .corr_thr (corr_thr_ff),
      .in_range (in_range),
      .started  (started),
      .idx      (IDX_W'(s1_sid_ff)),
      .entry    (entry),
      .pts_in   (s1_pts_ff),
      .dts_in   (s1_dts_ff),
      .dur      (s1_dur_ff),
      .result   (calc_res),
      .wr       (calc_wr)
   );

   always_comb begin
      mem_wr    = calc_wr;
      mem_wr.en = calc_wr.en && s1_adv;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_data_ff <= calc_res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_data_ff.dts_out, rsp_data_ff.pts_out};
   assign rsp_tuser  = {rsp_data_ff.offset_updated, rsp_data_ff.jump_seen};

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |=> (s1_valid_ff && $stable(s1_pts_ff) && $stable(s1_sid_ff)))
      else $error("input stage lost its item while stalled");

   a_upd_after_seed: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && calc_res.offset_updated) |-> started)
      else $error("offset updated on an unseeded stream");

   a_adv_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced item not presented");

   a_bypass: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && !enable_ff) |=> (rsp_data_ff.pts_out == $past(s1_pts_ff) &&
                                  rsp_data_ff.dts_out == $past(s1_dts_ff)))
      else $error("disabled reclock changed timestamps");

   a_no_write_disabled: assert property (@(posedge clock) disable iff (reset)
      (!enable_ff) |-> !mem_wr.en)
      else $error("state written while disabled");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for timestamp_monotonic_reclock_top: packets go in on req_*,
// a per-stream predictor computes each rsp_* item, csr_* sets enable and the thresholds.
// Depends only on tmr_pkg and the RTL.
module tb_top;
   import tmr_pkg::*;

   localparam int          CYCLE_LIMIT = 500000;
   localparam logic [63:0] TS_MAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] TS_MIN      = 64'h8000_0000_0000_0000;
   localparam logic [63:0] THR_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [159:0]          req_tdata = '0;   // pts_in, dts_in, pkt_duration
   logic [SID_W-1:0]      req_tuser = '0;   // stream_id
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [127:0]          rsp_tdata;        // pts_out, dts_out
   logic [1:0]            rsp_tuser;        // jump_seen, offset_updated
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   logic             cfg_enable;
   logic [THR_W-1:0] cfg_jump_thr;
   logic [THR_W-1:0] cfg_corr_thr;
   logic             stream_live  [NUM_STREAMS];
   logic [63:0]      pred_pts     [NUM_STREAMS];
   logic [63:0]      pred_dts     [NUM_STREAMS];
   logic [63:0]      stream_shift [NUM_STREAMS];

   result_type  expected_stamps[$];
   logic [63:0] source_clock[16];    // per-stream input timeline for well-formed packets
   int          error_count = 0;
   int          cycle_count = 0;
   bit          calm = 1'b1;
   int          hold_len = 0;
   int          hold_seq = 0;
   int          hold_taken = 0;
   int          stall_left = 0;

   timestamp_monotonic_reclock_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic int pick_idle();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      if (r < 98) return $urandom_range(4, 8);
      return $urandom_range(15, 40);
   endfunction

   function automatic logic [63:0] ts_distance(logic [63:0] a, logic [63:0] b);
      return (a >= b) ? a - b : b - a;
   endfunction

   function automatic result_type reclock_packet(logic [3:0] sid, logic [63:0] pts_in,
                                                 logic [63:0] dts_in, logic [31:0] dur);
      result_type  r;
      logic        pv, dv, dterm, pterm;
      logic [63:0] ep, ed, dmag, pmag, off;
      r.pts_out        = pts_in;
      r.dts_out        = dts_in;
      r.jump_seen      = 1'b0;
      r.offset_updated = 1'b0;
      pv = !pts_in[63];
      dv = !dts_in[63];
      if (cfg_enable && (pv || dv) && sid < NUM_STREAMS) begin
         if (!stream_live[sid]) begin
            pred_pts[sid]    = pts_in;
            pred_dts[sid]    = dts_in;
            stream_live[sid] = 1'b1;
         end else begin
            ep    = pred_pts[sid];
            ed    = pred_dts[sid];
            off   = stream_shift[sid];
            dterm = dv && !ed[63];
            pterm = pv && !ep[63];
            dmag  = dterm ? ts_distance(ed, dts_in) : 64'd0;
            pmag  = pterm ? ts_distance(ep, pts_in) : 64'd0;
            r.jump_seen = (dterm && dmag > {1'b0, cfg_jump_thr}) ||
                          (pterm && pmag > {1'b0, cfg_jump_thr});
            if (pv) r.pts_out = pts_in + off;
            if (dv) r.dts_out = dts_in + off;
            if (dmag > {1'b0, cfg_corr_thr} || pmag > {1'b0, cfg_corr_thr}) begin
               r.offset_updated = 1'b1;
               // larger error wins, ties go to pts
               if (dmag > pmag && dmag != 0)
                  stream_shift[sid] = off + (ed - r.dts_out + off);
               else if (pmag != 0)
                  stream_shift[sid] = off + (ep - r.pts_out + off);
            end
            pred_pts[sid] = r.pts_out + {32'd0, dur};
            pred_dts[sid] = r.dts_out + {32'd0, dur};
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
      error_count++;
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_stamps.size() == 0) begin
            report_mismatch("unexpected item pts_out", rsp_tdata[63:0], '0);
         end else begin
            want = expected_stamps.pop_front();
            if (rsp_tdata[63:0] !== want.pts_out)
               report_mismatch("pts_out", rsp_tdata[63:0], want.pts_out);
            if (rsp_tdata[127:64] !== want.dts_out)
               report_mismatch("dts_out", rsp_tdata[127:64], want.dts_out);
            if (rsp_tuser[0] !== want.jump_seen)
               report_mismatch("jump_seen", 64'(rsp_tuser[0]), 64'(want.jump_seen));
            if (rsp_tuser[1] !== want.offset_updated)
               report_mismatch("offset_updated", 64'(rsp_tuser[1]),
                               64'(want.offset_updated));
         end
      end
   end

   // receiver: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_seq != hold_taken) begin
         hold_taken = hold_seq;
         stall_left = hold_len;
      end else if (stall_left == 0 && !calm && $urandom_range(0, 3) == 0) begin
         stall_left = pick_idle();
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic send_packet(input logic [3:0] sid, input logic [63:0] pts,
                              input logic [63:0] dts, input logic [31:0] dur);
      int gap;
      gap = calm ? 0 : pick_idle();
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {dur, dts, pts};
      req_tuser  <= sid;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      expected_stamps.push_back(reclock_packet(sid, pts, dts, dur));
   endtask

   task automatic wait_quiet();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (expected_stamps.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] value);
      wait_quiet();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_ENABLE:   cfg_enable   = value[0];
         CSR_JUMP_THR: cfg_jump_thr = value[THR_W-1:0];
         CSR_CORR_THR: cfg_corr_thr = value[THR_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_mode(input logic en, input logic [63:0] jump_thr,
                           input logic [63:0] corr_thr);
      write_register(CSR_ENABLE, {63'd0, en});
      write_register(CSR_JUMP_THR, jump_thr);
      write_register(CSR_CORR_THR, corr_thr);
   endtask

   task automatic test_stream_start();
      send_packet(4'd0, 64'd1000, 64'd900, 32'd3000);
      send_packet(4'd0, 64'd4000, 64'd3900, 32'd3000);
      send_packet(4'd0, 64'd50_000_000, 64'd50_000_200, 32'd3000);
      send_packet(4'd0, 64'd50_003_000, 64'd50_003_200, 32'd3000);
   endtask

   task automatic test_error_choice();
      send_packet(4'd1, 64'd0, 64'd0, 32'd0);
      send_packet(4'd1, 64'd5_000_000, 64'd5_000_000, 32'd1);
      send_packet(4'd1, 64'd5_000_001, 64'd5_000_001, 32'd1);
      send_packet(4'd1, 64'd2_000_000, 64'd4_999_000, 32'd1);
   endtask

   task automatic test_absent_stamps();
      send_packet(4'd2, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'd10);
      send_packet(4'd2, TS_MIN, 64'd100, 32'd10);
      send_packet(4'd2, 64'd20_000_000, 64'd110, 32'd10);
      send_packet(4'd2, 64'hFFFF_FFFF_FFFF_FFF9, 64'd30_000_000, 32'd10);
   endtask

   task automatic test_field_extremes();
      send_packet(4'd15, TS_MAX, TS_MAX, 32'hFFFF_FFFF);
      send_packet(4'd15, TS_MAX, 64'd0, 32'hFFFF_FFFF);
      send_packet(4'd15, 64'd0, TS_MAX, 32'd0);
      send_packet(4'd15, TS_MAX, TS_MAX, 32'hFFFF_FFFF);
   endtask

   task automatic test_disabled();
      write_register(CSR_ENABLE, 64'd0);
      send_packet(4'd0, 64'd123, 64'd456, 32'd7);
      send_packet(4'd4, 64'd1, 64'd2, 32'd7);
      write_register(CSR_ENABLE, 64'd1);
      send_packet(4'd4, 64'd1, 64'd2, 32'd7);
      send_packet(4'd4, 64'd9, 64'd9, 32'd7);
   endtask

   task automatic test_threshold_extremes();
      set_mode(1'b1, 64'd0, 64'd0);
      send_packet(4'd4, 64'd17, 64'd16, 32'd5);
      send_packet(4'd4, 64'd22, 64'd21, 32'd5);
      set_mode(1'b1, THR_MAX, THR_MAX);
      send_packet(4'd4, TS_MAX, 64'd0, 32'd5);
      send_packet(4'd4, 64'd0, TS_MAX, 32'd5);
   endtask

   // output held off while the sender keeps offering, so the input side backs up
   task automatic test_backpressure();
      int i;
      set_mode(1'b1, 64'd10_000_000, 64'd1_000_000);
      calm = 1'b1;
      hold_len = 150;
      hold_seq++;
      for (i = 0; i < 30; i++)
         send_packet(4'(i % 3), 64'(1000 * i), 64'(1000 * i + 5), 32'd1000);
      wait_quiet();
   endtask

   function automatic logic [63:0] pick_step();
      logic [63:0] s;
      case ($urandom_range(0, 4))
         0:       s = $urandom_range(0, 2000);
         1:       s = {1'b0, cfg_corr_thr} - 64'd1 + $urandom_range(0, 2);
         2:       s = {1'b0, cfg_jump_thr} - 64'd1 + $urandom_range(0, 2);
         3:       s = {24'd0, 8'($urandom), $urandom};
         default: s = {2'b00, 62'(rand64())};
      endcase
      return $urandom_range(0, 1) ? s : -s;
   endfunction

   task automatic send_random_packets(input int count);
      int          n, kind;
      logic [3:0]  sid;
      logic [63:0] pts, dts;
      logic [31:0] dur;
      for (n = 0; n < count; n++) begin
         if ($urandom_range(0, 49) == 0) calm = !calm;
         sid  = ($urandom_range(0, 3) != 0) ? 4'($urandom_range(0, 3)) : 4'($urandom);
         kind = $urandom_range(0, 99);
         dur  = ($urandom_range(0, 9) == 0) ? $urandom : 32'($urandom_range(0, 4000));
         if (kind >= 94) begin
            pts = rand64();
            dts = rand64();
            if ($urandom_range(0, 1)) source_clock[sid] = dts;
         end else begin
            if (kind < 12) source_clock[sid] = source_clock[sid] + pick_step();
            dts = source_clock[sid];
            pts = dts + $urandom_range(0, 3000);
            if (kind >= 12 && kind < 20) pts = {1'b1, 63'(rand64())};
            if (kind >= 20 && kind < 26) dts = {1'b1, 63'(rand64())};
            if (kind >= 26 && kind < 29) begin
               pts = {1'b1, 63'(rand64())};
               dts = {1'b1, 63'(rand64())};
            end
            source_clock[sid] = source_clock[sid] + {32'd0, dur};
         end
         send_packet(sid, pts, dts, dur);
      end
      calm = 1'b0;
   endtask

   task automatic test_random_settings();
      int i;
      for (i = 0; i < 16; i++)
         source_clock[i] = ($urandom_range(0, 7) == 0) ? TS_MAX - $urandom_range(0, 100000)
                                                        : {31'd0, 33'(rand64())};
      calm = 1'b0;
      set_mode(1'b1, 64'd10_000_000, 64'd1_000_000);
      send_random_packets(250);
      set_mode(1'b1, 64'd5000, 64'd800);
      send_random_packets(150);
      set_mode(1'b1, 64'd0, 64'd0);
      send_random_packets(100);
      set_mode(1'b1, THR_MAX, THR_MAX);
      send_random_packets(100);
      set_mode(1'b1, 64'd1000, 64'd50_000);
      send_random_packets(120);
      set_mode(1'b0, 64'd1000, 64'd50_000);
      send_random_packets(50);
      set_mode(1'b1, 64'($urandom_range(0, 2_000_000)), 64'($urandom_range(0, 2_000_000)));
      send_random_packets(130);
   endtask

   initial begin
      int i;
      cfg_enable   = ENABLE_RESET;
      cfg_jump_thr = JUMP_THR_RESET;
      cfg_corr_thr = CORR_THR_RESET;
      for (i = 0; i < NUM_STREAMS; i++) begin
         stream_live[i]  = 1'b0;
         pred_pts[i]     = '0;
         pred_dts[i]     = '0;
         stream_shift[i] = '0;
      end
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_stream_start();
      test_error_choice();
      test_absent_stamps();
      test_field_extremes();
      test_disabled();
      test_threshold_extremes();
      test_backpressure();
      test_random_settings();

      wait_quiet();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// File: timestamp_monotonic_reclock_top.f
rtl/tmr_pkg.sv
rtl/tmr_state_mem.sv
rtl/tmr_calc.sv
rtl/timestamp_monotonic_reclock_top.sv
test/tb_top.sv
